// File: hdl/lf4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lf4_pkg: shared types, constants and fixed-point helpers
// Integrator format, register indexes, rounding and saturation used by the
// four-pole ladder filter datapath and its output mixer.
// ----------------------------------------------------------------------------
package lf4_pkg;

  // integrator and internal word width
  localparam int INT_W    = 32;
  // working width of the rounding and saturation helpers
  localparam int WIDE_W   = 64;
  // fraction bits of the coefficient and resonance products
  localparam int COEF_FRAC = 23;
  localparam int K_FRAC    = 21;
  // register widths
  localparam int COEF_W   = 23;
  localparam int REG_W    = 24;
  localparam int CFG_IDX_W = 3;
  // number of filter stages and of output mixes
  localparam int NUM_STAGE = 4;
  localparam int NUM_OUT   = 6;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WEIGHT_ONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WEIGHT_TWO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WEIGHT_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WEIGHT_FOU = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESONANCE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE   = 3'd6;

  // reset value of the input scale, 1.0 in unsigned Q1.23
  localparam logic [REG_W-1:0] INPUT_SCALE_RST = 24'h800000;

  // saturation limits of an integrator word
  localparam logic signed [WIDE_W-1:0] INT_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [WIDE_W-1:0] INT_MIN = -INT_MAX - 64'sd1;

  // filter taps handed to the output mixer
  typedef struct packed {
    logic signed [INT_W-1:0] u;
    logic signed [INT_W-1:0] lp1;
    logic signed [INT_W-1:0] lp2;
    logic signed [INT_W-1:0] lp3;
    logic signed [INT_W-1:0] lp4;
  } lf4_taps_t;

  // add half an lsb then shift right arithmetically (round half up)
  function automatic logic signed [WIDE_W-1:0] round_shift(
    input logic signed [WIDE_W-1:0] v,
    input int unsigned              s
  );
    logic signed [WIDE_W-1:0] half;
    half = 64'sd1 <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  // clamp to the signed integrator range
  function automatic logic signed [INT_W-1:0] sat_int(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [INT_W-1:0] r;
    if (v > INT_MAX) begin
      r = INT_MAX[INT_W-1:0];
    end else if (v < INT_MIN) begin
      r = INT_MIN[INT_W-1:0];
    end else begin
      r = v[INT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/lf4_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lf4_mix: multimode output mixer
// Forms the lowpass, bandpass and highpass mixes of the stage outputs exactly
// and saturates each to the sample width. Packed lowest mix first.
// ----------------------------------------------------------------------------
module lf4_mix import lf4_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  lf4_taps_t                          taps_i,
  // lp2, lp4, bp2, bp4, hp2, hp4 from the lowest bits up
  output logic [NUM_OUT*SAMPLE_WIDTH-1:0]    mix_o
);

  // room for the widest mix, sixteen times a tap
  localparam int MW = INT_W + 6;
  localparam logic signed [MW-1:0] SMP_MAX =
    MW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [MW-1:0] SMP_MIN = -SMP_MAX - MW'(1);

  function automatic logic [SAMPLE_WIDTH-1:0] sat_smp(input logic signed [MW-1:0] v);
    logic [SAMPLE_WIDTH-1:0] r;
    if (v > SMP_MAX) begin
      r = SMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (v < SMP_MIN) begin
      r = SMP_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      r = v[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

  logic signed [MW-1:0] e_u, e_l1, e_l2, e_l3, e_l4;
  logic signed [MW-1:0] bp2, bp4, hp2, hp4;

  // sign-extend the taps
  assign e_u  = MW'(taps_i.u);
  assign e_l1 = MW'(taps_i.lp1);
  assign e_l2 = MW'(taps_i.lp2);
  assign e_l3 = MW'(taps_i.lp3);
  assign e_l4 = MW'(taps_i.lp4);

  // exact mixes
  assign bp2 = (e_l1 <<< 1) - (e_l2 <<< 1);
  assign bp4 = (e_l2 <<< 2) - (e_l3 <<< 3) + (e_l4 <<< 2);
  assign hp2 = e_u - (e_l1 <<< 1) + e_l2;
  assign hp4 = e_u - (e_l1 <<< 2) + (e_l2 <<< 2) + (e_l2 <<< 1) - (e_l3 <<< 2) + e_l4;

  // saturate and pack
  assign mix_o = {sat_smp(hp4), sat_smp(hp2), sat_smp(bp4),
                  sat_smp(bp2), sat_smp(e_l4), sat_smp(e_l2)};

endmodule
`default_nettype wire

// File: hdl/ladder_filter_4pole_multimode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ladder_filter_4pole_multimode: four-pole zero-delay-feedback ladder filter
// samples are taken one at a time, only while idle; all products go through one shared
//   34x25 multiplier under the sequencer (4 feedback, 2 scale, 4 stage mults)
// a stalled result beat holds the sequencer in its last step until taken
// reset: asynchronous, active low; integrators clear, registers take defaults
// ----------------------------------------------------------------------------
module ladder_filter_4pole_multimode import lf4_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // configuration write channel
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]                  cfg_index_i,
  input  wire  [REG_W-1:0]                      cfg_data_i,
  // sample input
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sample_in
  input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // result output
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // lowpass_two, lowpass_four, bandpass_two, bandpass_four,
  // highpass_two, highpass_four
  output logic [((NUM_OUT*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OUT_W    = NUM_OUT * SAMPLE_WIDTH;
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;
  localparam int MA_W     = INT_W + 2;
  localparam int MB_W     = REG_W + 1;
  localparam int P_W      = MA_W + MB_W;
  localparam int ACC_W    = P_W + 1;
  localparam int D_W      = INT_W + 1;
  localparam int V_W      = INT_W + 4;
  localparam int IDX_W    = $clog2(NUM_STAGE);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_SIG  = 13'b0000000000010,
    ST_SACC = 13'b0000000000100,
    ST_SSAT = 13'b0000000001000,
    ST_KMUL = 13'b0000000010000,
    ST_FBS  = 13'b0000000100000,
    ST_AMUL = 13'b0000001000000,
    ST_USAT = 13'b0000010000000,
    ST_SD   = 13'b0000100000000,
    ST_SM   = 13'b0001000000000,
    ST_SL   = 13'b0010000000000,
    ST_SZ   = 13'b0100000000000,
    ST_MIX  = 13'b1000000000000
  } lf4_state_e;

  lf4_state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q;

  // configuration registers
  logic [COEF_W-1:0] alpha_q;
  logic [COEF_W-1:0] beta_q [NUM_STAGE];
  logic [REG_W-1:0]  k_q;
  logic [REG_W-1:0]  alpha0_q;

  // filter state
  logic signed [INT_W-1:0] z_q [NUM_STAGE];

  // datapath registers
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [P_W-1:0]   p_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [INT_W-1:0] t_q;
  logic signed [INT_W-1:0] u_q;
  logic signed [D_W-1:0]   d_q;
  logic signed [V_W-1:0]   v_q;
  logic signed [INT_W-1:0] lp_q [NUM_STAGE];

  // output register
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_q;

  logic                    in_beat, out_beat, out_load;
  logic signed [MA_W-1:0]  mult_a;
  logic signed [MB_W-1:0]  mult_b;
  logic signed [INT_W-1:0] z_sel;
  logic [COEF_W-1:0]       beta_sel;
  logic signed [WIDE_W-1:0] v_rnd;
  logic signed [INT_W-1:0] lp_new;
  lf4_taps_t               taps;
  logic [OUT_W-1:0]        mix;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;
  assign out_load      = (state_q == ST_MIX) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TD_W'(out_q);

  assign z_sel    = z_q[idx_q];
  assign beta_sel = beta_q[idx_q];

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      ST_SIG: begin
        mult_a = MA_W'(z_sel);
        mult_b = MB_W'(beta_sel);
      end
      ST_KMUL: begin
        mult_a = MA_W'(t_q);
        mult_b = MB_W'(k_q);
      end
      ST_AMUL: begin
        mult_a = MA_W'(t_q);
        mult_b = MB_W'(alpha0_q);
      end
      ST_SM: begin
        mult_a = MA_W'(d_q);
        mult_b = MB_W'(alpha_q);
      end
      default: begin
        mult_a = '0;
        mult_b = '0;
      end
    endcase
  end

  // stage update: v and the new stage output
  assign v_rnd  = round_shift(WIDE_W'(p_q), COEF_FRAC);
  assign lp_new = sat_int(v_rnd + WIDE_W'(z_sel));

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_beat) state_d = ST_SIG;
      ST_SIG:  if (idx_q == IDX_W'(NUM_STAGE - 1)) state_d = ST_SACC;
      ST_SACC: state_d = ST_SSAT;
      ST_SSAT: state_d = ST_KMUL;
      ST_KMUL: state_d = ST_FBS;
      ST_FBS:  state_d = ST_AMUL;
      ST_AMUL: state_d = ST_USAT;
      ST_USAT: state_d = ST_SD;
      ST_SD:   state_d = ST_SM;
      ST_SM:   state_d = ST_SL;
      ST_SL:   state_d = ST_SZ;
      ST_SZ: begin
        if (idx_q == IDX_W'(NUM_STAGE - 1)) state_d = ST_MIX;
        else state_d = ST_SD;
      end
      ST_MIX:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, configuration and integrators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      alpha_q     <= '0;
      k_q         <= '0;
      alpha0_q    <= INPUT_SCALE_RST;
      for (int i = 0; i < NUM_STAGE; i++) begin
        beta_q[i] <= '0;
        z_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;

      // stage index steps through the feedback taps and the stages
      if ((state_q == ST_SIG) || (state_q == ST_SZ)) begin
        idx_q <= idx_q + IDX_W'(1);
      end else if (state_q == ST_USAT) begin
        idx_q <= '0;
      end

      // integrator write-back
      if (state_q == ST_SZ) begin
        z_q[idx_q] <= sat_int(WIDE_W'(v_q) + WIDE_W'(t_q));
      end

      // result beat handshake
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_beat) begin
        out_valid_q <= 1'b0;
      end

      // register writes, unknown index ignored
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_STAGE_GAIN:    alpha_q   <= cfg_data_i[COEF_W-1:0];
          REG_FB_WEIGHT_ONE: beta_q[0] <= cfg_data_i[COEF_W-1:0];
          REG_FB_WEIGHT_TWO: beta_q[1] <= cfg_data_i[COEF_W-1:0];
          REG_FB_WEIGHT_THR: beta_q[2] <= cfg_data_i[COEF_W-1:0];
          REG_FB_WEIGHT_FOU: beta_q[3] <= cfg_data_i[COEF_W-1:0];
          REG_RESONANCE:     k_q       <= cfg_data_i;
          REG_INPUT_SCALE:   alpha0_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= mult_a * mult_b;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) x_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
      end
      // feedback sum accumulates the previous product
      ST_SIG: begin
        if (idx_q == '0) acc_q <= '0;
        else acc_q <= acc_q + ACC_W'(p_q);
      end
      ST_SACC: acc_q <= acc_q + ACC_W'(p_q);
      ST_SSAT: t_q <= sat_int(round_shift(WIDE_W'(acc_q), COEF_FRAC));
      // input minus resonance feedback
      ST_FBS: begin
        t_q <= sat_int(WIDE_W'(x_q) - round_shift(WIDE_W'(p_q), K_FRAC));
      end
      ST_USAT: begin
        t_q <= sat_int(round_shift(WIDE_W'(p_q), COEF_FRAC));
        u_q <= sat_int(round_shift(WIDE_W'(p_q), COEF_FRAC));
      end
      // one-pole stage: difference, product, output
      ST_SD: d_q <= D_W'(t_q) - D_W'(z_sel);
      ST_SL: begin
        v_q          <= v_rnd[V_W-1:0];
        t_q          <= lp_new;
        lp_q[idx_q]  <= lp_new;
      end
      ST_MIX: begin
        if (out_load) out_q <= mix;
      end
      default: ;
    endcase
  end

  // output mixer
  assign taps.u   = u_q;
  assign taps.lp1 = lp_q[0];
  assign taps.lp2 = lp_q[1];
  assign taps.lp3 = lp_q[2];
  assign taps.lp4 = lp_q[3];

  lf4_mix #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mix (
    .taps_i(taps),
    .mix_o (mix)
  );

endmodule
`default_nettype wire

// File: hdl/lf4_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lf4_checker: port-level checks of the ladder filter
// Watches the sample and result channels for sequencing slips; bound to the
// top level below.
// ----------------------------------------------------------------------------
module lf4_checker import lf4_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input wire                                       clk_i,
  input wire                                       rst_ni,
  input wire                                       s_axis_tvalid,
  input wire                                       s_axis_tready,
  input wire                                       m_axis_tvalid,
  input wire                                       m_axis_tready,
  input wire [((NUM_OUT*SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // the block is busy right after taking a sample
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready after sample beat");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

  // returning to idle always leaves a result behind
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid)
    else $error("sequencer finished without a result");

endmodule

bind ladder_filter_4pole_multimode lf4_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
